// ===== design/session_handshake_engine_defines.svh =====
// Assertion macros for the session handshake engine.
`ifndef SESSION_HANDSHAKE_ENGINE_DEFINES_SVH
`define SESSION_HANDSHAKE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define SHE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define SHE_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define SHE_ASSERT(lbl, prop, msg)
`define SHE_NEVER(lbl, cond, msg)
`endif

`endif

// ===== design/shs_pkg.sv =====
// Types and constants shared by the session handshake engine modules.
`default_nettype none

package shs_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ROT_SHIFT   = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_NONCE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_NONCE    = 2'd2;

    localparam logic [7:0] MSG_START_INIT  = 8'd0;
    localparam logic [7:0] MSG_START_REPLY = 8'd1;
    localparam logic [7:0] MSG_TERMINATE   = 8'd2;
    localparam logic [7:0] MSG_LOG         = 8'd3;

    typedef enum logic [2:0] {
        OP_INIT    = 3'd0,
        OP_START   = 3'd1,
        OP_SEND    = 3'd2,
        OP_PACKET  = 3'd3,
        OP_RELEASE = 3'd4,
        OP_WRITE   = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        KIND_STATUS  = 3'd0,
        KIND_TX      = 3'd1,
        KIND_DELIVER = 3'd2,
        KIND_EST     = 3'd3,
        KIND_TERM    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_INVALID  = 2'd1,
        STS_BUSY     = 2'd2,
        STS_NOT_INIT = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_RESET = 4'b0001,
        ST_NONE  = 4'b0010,
        ST_SENT  = 4'b0100,
        ST_EST   = 4'b1000
    } t_state;

    // Input tdata, lowest field declared last.
    typedef struct packed {
        logic [4:0] pad;
        logic [7:0] rx_version;
        logic [7:0] rx_responder_nonce;
        logic [7:0] rx_initiator_nonce;
        logic       payload_complete;
        logic       header_complete;
        logic       packet_valid;
        logic [7:0] msg_type;
    } t_in_data;

    // Output tdata, lowest field declared last.
    typedef struct packed {
        logic [4:0] pad;
        t_status    status;
        logic       with_version_payload;
        logic [7:0] out_responder_nonce;
        logic [7:0] out_initiator_nonce;
        logic [7:0] out_msg_type;
    } t_out_data;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] msg_type;
        logic [7:0] ini;
        logic [7:0] rsp;
        logic       ver;
        t_status    status;
    } t_result;

    // All results caused by one input item; cnt is 1 to 3.
    typedef struct packed {
        t_result [2:0] res;
        logic [1:0]    cnt;
    } t_plan;

    // Handshake between a producer and a consumer of plans.
    typedef struct packed {
        logic  valid;
        t_plan plan;
    } t_plan_link;

    localparam t_result RES_NONE = '{kind: KIND_STATUS, msg_type: 8'd0, ini: 8'd0,
                                     rsp: 8'd0, ver: 1'b0, status: STS_OK};

endpackage

`default_nettype wire

// ===== design/shs_fifo.sv =====
// Short plan queue between the command front end and the result sequencer.
`default_nettype none
`include "session_handshake_engine_defines.svh"

module shs_fifo import shs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_plan_link i_push,
    output logic       o_full,
    output t_plan_link o_head,
    input  logic       i_pop
);

    t_plan               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.plan  = r_mem[r_rd];
    assign do_push     = i_push.valid && !o_full;
    assign do_pop      = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.plan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `SHE_NEVER(a_no_overflow, i_push.valid && o_full, "plan pushed into a full queue")
    `SHE_ASSERT(a_count_bound, r_count <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

// ===== design/shs_front.sv =====
// Command front end: config registers, session state and result planning.
`default_nettype none

module shs_front import shs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [2:0]           i_in_op,
    input  t_in_data             i_in_data,
    output t_plan_link           o_push,
    input  logic                 i_q_full
);

    logic [7:0] r_init_nonce;
    logic [7:0] r_proto_ver;
    logic [7:0] r_inv_nonce;

    t_state     r_state;
    logic [7:0] r_local;
    logic [7:0] r_sinit;
    logic [7:0] r_sresp;
    logic       r_buf_full;

    t_state     n_state;
    logic [7:0] n_local;
    logic [7:0] n_sinit;
    logic [7:0] n_sresp;
    logic       n_buf_full;
    t_plan      n_plan;

    logic       accept;
    logic [7:0] nn;

    function automatic logic [7:0] next_nonce(logic [7:0] n, logic [7:0] inv);
        logic [7:0] t;
        t = (8'(n << ROT_SHIFT) | (n >> ROT_SHIFT)) + 8'd1;
        if (t == inv) begin
            t = t + 8'd1;
        end
        return t;
    endfunction

    function automatic t_result mk(t_kind k, logic [7:0] ty, logic [7:0] ini,
                                   logic [7:0] rsp, logic ver, t_status st);
        t_result r;
        r.kind     = k;
        r.msg_type = ty;
        r.ini      = ini;
        r.rsp      = rsp;
        r.ver      = ver;
        r.status   = st;
        return r;
    endfunction

    assign o_in_ready   = !i_q_full;
    assign accept       = i_in_valid && o_in_ready;
    assign nn           = next_nonce(r_local, r_inv_nonce);
    assign o_push.valid = accept;
    assign o_push.plan  = n_plan;

    always_comb begin
        logic [7:0] ty;
        logic [7:0] ini;
        logic [7:0] rsp;
        logic       match;
        logic [1:0] cnt;
        ty    = i_in_data.msg_type;
        ini   = i_in_data.rx_initiator_nonce;
        rsp   = i_in_data.rx_responder_nonce;
        match = (ini == r_sinit) && (rsp == r_sresp);
        cnt   = 2'd0;

        n_state    = r_state;
        n_local    = r_local;
        n_sinit    = r_sinit;
        n_sresp    = r_sresp;
        n_buf_full = r_buf_full;
        n_plan.res = {RES_NONE, RES_NONE, RES_NONE};

        unique case (i_in_op)
            OP_INIT: begin
                n_local       = r_init_nonce;
                n_sinit       = 8'd0;
                n_sresp       = 8'd0;
                n_state       = ST_NONE;
                n_plan.res[0] = mk(KIND_TX, MSG_TERMINATE, 8'd0, 8'd0, 1'b0, STS_OK);
                cnt           = 2'd1;
            end
            OP_START: begin
                if (r_state == ST_RESET) begin
                    n_plan.res[0] = mk(KIND_STATUS, 8'd0, 8'd0, 8'd0, 1'b0, STS_NOT_INIT);
                end else begin
                    n_local       = nn;
                    n_sinit       = nn;
                    n_sresp       = 8'd0;
                    n_state       = ST_SENT;
                    n_plan.res[0] = mk(KIND_TX, MSG_START_INIT, nn, 8'd0, 1'b1, STS_OK);
                end
                cnt = 2'd1;
            end
            OP_SEND: begin
                if (r_state != ST_EST && ty != MSG_LOG) begin
                    n_plan.res[0] = mk(KIND_STATUS, 8'd0, 8'd0, 8'd0, 1'b0, STS_INVALID);
                end else if (ty == MSG_LOG) begin
                    n_plan.res[0] = mk(KIND_TX, MSG_LOG, 8'd0, 8'd0, 1'b0, STS_OK);
                end else begin
                    n_plan.res[0] = mk(KIND_TX, ty, r_sinit, r_sresp, 1'b0, STS_OK);
                end
                cnt = 2'd1;
            end
            OP_PACKET: begin
                if (i_in_data.packet_valid && i_in_data.header_complete) begin
                    n_buf_full = 1'b1;
                    case (ty)
                        MSG_START_INIT: begin
                            logic do_reply;
                            logic do_init;
                            n_buf_full = 1'b0;
                            do_reply   = 1'b0;
                            do_init    = 1'b0;
                            if (ini != r_inv_nonce && i_in_data.payload_complete) begin
                                if (r_state == ST_SENT) begin
                                    if (ini < r_local) begin
                                        do_reply = (i_in_data.rx_version == r_proto_ver);
                                    end else if (ini == r_local) begin
                                        // equal nonces: both sides restart
                                        do_init = 1'b1;
                                    end
                                end else begin
                                    do_reply = 1'b1;
                                end
                            end
                            if (do_reply) begin
                                n_local       = nn;
                                n_sinit       = ini;
                                n_sresp       = nn;
                                n_state       = ST_EST;
                                n_plan.res[0] = mk(KIND_TX, MSG_START_REPLY, ini, nn,
                                                   1'b1, STS_OK);
                                n_plan.res[1] = mk(KIND_EST, MSG_START_REPLY, 8'd0, 8'd0,
                                                   1'b0, STS_OK);
                                cnt           = 2'd2;
                                if (r_state == ST_EST) begin
                                    n_plan.res[2] = n_plan.res[1];
                                    cnt           = 2'd3;
                                end
                            end else if (do_init) begin
                                n_local       = nn;
                                n_sinit       = nn;
                                n_sresp       = 8'd0;
                                n_state       = ST_SENT;
                                n_plan.res[0] = mk(KIND_TX, MSG_START_INIT, nn, 8'd0,
                                                   1'b1, STS_OK);
                                cnt           = 2'd1;
                            end
                        end
                        MSG_START_REPLY: begin
                            n_buf_full = 1'b0;
                            if (rsp != r_inv_nonce && i_in_data.payload_complete) begin
                                if (r_state == ST_SENT) begin
                                    if (ini == r_local &&
                                        i_in_data.rx_version == r_proto_ver) begin
                                        n_sinit       = r_local;
                                        n_sresp       = rsp;
                                        n_state       = ST_EST;
                                        n_plan.res[0] = mk(KIND_EST, MSG_START_REPLY, 8'd0,
                                                           8'd0, 1'b0, STS_OK);
                                        cnt           = 2'd1;
                                    end
                                end else if (r_state == ST_EST) begin
                                    n_state = ST_RESET;
                                end
                            end
                        end
                        MSG_TERMINATE: begin
                            n_buf_full = 1'b0;
                            if (r_state == ST_EST) begin
                                n_state       = ST_NONE;
                                n_plan.res[0] = mk(KIND_TERM, MSG_TERMINATE, 8'd0, 8'd0,
                                                   1'b0, STS_OK);
                                cnt           = 2'd1;
                            end
                        end
                        MSG_LOG: begin
                            if ((ini == 8'd0 && rsp == 8'd0) || match) begin
                                n_plan.res[0] = mk(KIND_DELIVER, MSG_LOG, 8'd0, 8'd0,
                                                   1'b0, STS_OK);
                                cnt           = 2'd1;
                            end
                        end
                        default: begin
                            if (r_state == ST_EST && match) begin
                                n_plan.res[0] = mk(KIND_DELIVER, ty, 8'd0, 8'd0,
                                                   1'b0, STS_OK);
                                cnt           = 2'd1;
                            end
                        end
                    endcase
                end
            end
            OP_RELEASE: begin
                n_buf_full = 1'b0;
            end
            OP_WRITE: begin
                if (r_buf_full) begin
                    n_plan.res[0] = mk(KIND_STATUS, 8'd0, 8'd0, 8'd0, 1'b0, STS_BUSY);
                    cnt           = 2'd1;
                end
            end
            default: begin
            end
        endcase

        // nothing to report still yields one status-ok item
        n_plan.cnt = (cnt == 2'd0) ? 2'd1 : cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_nonce <= 8'd0;
            r_proto_ver  <= 8'd0;
            r_inv_nonce  <= 8'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_INITIAL_NONCE:    r_init_nonce <= i_cfg_data;
                CFG_PROTOCOL_VERSION: r_proto_ver  <= i_cfg_data;
                CFG_INVALID_NONCE:    r_inv_nonce  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RESET;
            r_local    <= 8'd0;
            r_sinit    <= 8'd0;
            r_sresp    <= 8'd0;
            r_buf_full <= 1'b0;
        end else if (accept) begin
            r_state    <= n_state;
            r_local    <= n_local;
            r_sinit    <= n_sinit;
            r_sresp    <= n_sresp;
            r_buf_full <= n_buf_full;
        end
    end

endmodule

`default_nettype wire

// ===== design/shs_back.sv =====
// Result sequencer: plays out each plan one result item per cycle while tready is high.
`default_nettype none
`include "session_handshake_engine_defines.svh"

module shs_back import shs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_plan_link i_head,
    output logic       o_pop,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output t_out_data  o_m_axis_tdata,
    output logic [2:0] o_m_axis_tuser,
    output logic       o_m_axis_tlast
);

    t_plan      r_plan;
    logic [1:0] r_slot;
    logic       r_have;
    logic       last;
    logic       out_acc;
    logic       load;
    t_result    cur;

    assign cur     = r_plan.res[r_slot];
    assign last    = (r_slot == r_plan.cnt - 2'd1);
    assign out_acc = r_have && i_m_axis_tready;
    assign o_pop   = !r_have || (out_acc && last);
    assign load    = o_pop && i_head.valid;

    assign o_m_axis_tvalid                     = r_have;
    assign o_m_axis_tlast                      = last;
    assign o_m_axis_tuser                      = cur.kind;
    assign o_m_axis_tdata.pad                  = '0;
    assign o_m_axis_tdata.status               = cur.status;
    assign o_m_axis_tdata.with_version_payload = cur.ver;
    assign o_m_axis_tdata.out_responder_nonce  = cur.rsp;
    assign o_m_axis_tdata.out_initiator_nonce  = cur.ini;
    assign o_m_axis_tdata.out_msg_type         = cur.msg_type;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_plan <= i_head.plan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_slot <= 2'd0;
        end else if (load) begin
            r_have <= 1'b1;
            r_slot <= 2'd0;
        end else if (out_acc) begin
            if (last) begin
                r_have <= 1'b0;
            end else begin
                r_slot <= r_slot + 2'd1;
            end
        end
    end

    `SHE_ASSERT(a_cnt_range, r_have |-> (r_plan.cnt != 2'd0), "plan with no result items")
    `SHE_ASSERT(a_slot_range, r_have |-> (r_slot < r_plan.cnt), "result slot past plan end")

endmodule

`default_nettype wire

// ===== design/session_handshake_engine.sv =====
// Top level of the session handshake engine.
//
//  channel   dir  accept               payload
//  s_axis    in   tvalid & tready      tuser: operation; tdata: header fields
//  m_axis    out  tvalid & tready      tuser: kind; tdata: result fields; tlast
//  cfg       in   i_cfg_wr_en          i_cfg_idx, i_cfg_data
//
// An input item is taken on tvalid & tready; the front end updates the session state
// at once and queues a plan of one to three result items (4-entry queue).
// The sequencer sends one result item per cycle while tready is high. Results pass
// the plan queue and plan register. Input stalls only when the plan queue is full.
// Synchronous active-low reset clears the state machine, nonces, busy flag,
// config registers and the queue; there is no clearing pass.
`default_nettype none

module session_handshake_engine import shs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // operation[2:0]
    input  logic [2:0]           i_s_axis_tuser,
    // msg_type, packet_valid, header_complete, payload_complete,
    // rx_initiator_nonce, rx_responder_nonce, rx_version, zero pad
    input  logic [39:0]          i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // kind[2:0]
    output logic [2:0]           o_m_axis_tuser,
    // out_msg_type, out_initiator_nonce, out_responder_nonce,
    // with_version_payload, status, zero pad
    output logic [31:0]          o_m_axis_tdata,
    output logic                 o_m_axis_tlast
);

    t_plan_link push;
    t_plan_link head;
    logic       q_full;
    logic       pop;
    t_out_data  out_data;

    shs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_op     (i_s_axis_tuser),
        .i_in_data   (t_in_data'(i_s_axis_tdata)),
        .o_push      (push),
        .i_q_full    (q_full)
    );

    shs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    shs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = 32'(out_data);

endmodule

`default_nettype wire
